[rtl/core/pli_pkg.sv]
// Package for the piecewise-linear interpolator: table sizing, command and
// status codes. Depends on nothing; every other file of the block uses it.
package pli_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W      = 16;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BELOW = 2'd1,
    STAT_ABOVE = 2'd2
  } status_t;

endpackage

[rtl/core/pli_if.sv]
// Request and result channel interfaces of the interpolator.
// Depends on pli_pkg for the field widths.
interface pli_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           cmd;
  logic signed [pli_pkg::KEY_W-1:0]     arg_key;
  logic signed [pli_pkg::VAL_W-1:0]     arg_value;

  modport source (output valid, cmd, arg_key, arg_value, input ready);
  modport sink   (input valid, cmd, arg_key, arg_value, output ready);
endinterface

interface pli_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic signed [pli_pkg::VAL_W-1:0]     out_value;

  modport source (output valid, status, out_value, input ready);
  modport sink   (input valid, status, out_value, output ready);
endinterface

[rtl/core/piecewise_linear_interpolator_unit.sv]
// Piecewise-linear interpolator: breakpoint memory, table walk sequencer and
// a shift-subtract divider. Depends on pli_pkg and the pli_if channels.
//
// Usage. Requests arrive on in_req (valid/ready). A clear request empties the
// breakpoint table and an append request writes one (key, value) breakpoint at
// its end; both are done when taken, give no result, and an append to
// a full table is dropped. A query request walks the table from the first
// breakpoint and returns one result on out_rsp: status in range, below or
// above, with the interpolated value when in range and zero otherwise.
// A query on an empty table goes straight to the output register with status
// below; with one entry, the key is compared with that breakpoint alone;
// otherwise the walk steps through the spans until the key falls on an
// endpoint, before the first key or past the last one. When the key falls
// strictly inside a span, the difference product is formed, divided one
// quotient bit per cycle by a single subtractor, and the signed quotient is
// added to the span's first value. One request at a time: in_req.ready is
// high only while the sequencer is idle. A stalled result is held in its
// output register and no new request is taken until it has been accepted.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the
// table; the breakpoint memory itself is not cleared.
module piecewise_linear_interpolator_unit (
  input logic       clk,
  input logic       rst_n,
  pli_req_if.sink   in_req,
  pli_rsp_if.source out_rsp
);

  localparam int IW = pli_pkg::IDX_W;
  localparam int CW = pli_pkg::CNT_W;
  localparam int KW = pli_pkg::KEY_W;
  localparam int VW = pli_pkg::VAL_W;
  localparam int PW = pli_pkg::PROD_W;
  localparam int DW = pli_pkg::DIV_CNT_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_WALK = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_ADJ  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  // Breakpoint memory: key in the upper half, value in the lower half.
  logic [KW+VW-1:0] bp_mem [pli_pkg::TABLE_DEPTH];
  logic [KW+VW-1:0] rdata_r;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic signed [KW-1:0]   key_r, key_nxt;
  logic signed [KW-1:0]   k0_r, k0_nxt;
  logic signed [VW-1:0]   v0_r, v0_nxt;
  logic [KW-1:0]          den_r, den_nxt;
  logic [KW-1:0]          dk_r, dk_nxt;
  logic [VW-1:0]          dv_mag_r, dv_mag_nxt;
  logic                   dv_neg_r, dv_neg_nxt;
  logic [PW-1:0]          dq_r, dq_nxt;
  logic [KW:0]            rem_r, rem_nxt;
  logic [DW-1:0]          div_cnt_r, div_cnt_nxt;
  logic [1:0]             status_r, status_nxt;
  logic signed [VW-1:0]   value_r, value_nxt;

  logic                   mem_we;
  logic signed [KW-1:0]   rd_key;
  logic signed [VW-1:0]   rd_val;
  logic signed [KW:0]     span_diff;
  logic signed [KW:0]     key_diff;
  logic signed [VW:0]     val_diff;
  logic [KW:0]            rem_sh;
  logic [KW:0]            rem_sub;
  logic signed [VW:0]     quot_s;
  logic signed [VW:0]     result_s;
  logic                   req_fire;

  assign rd_key    = rdata_r[KW+VW-1:VW];
  assign rd_val    = rdata_r[VW-1:0];
  assign span_diff = {rd_key[KW-1], rd_key} - {k0_r[KW-1], k0_r};
  assign key_diff  = {key_r[KW-1], key_r} - {k0_r[KW-1], k0_r};
  assign val_diff  = {rd_val[VW-1], rd_val} - {v0_r[VW-1], v0_r};

  // One restoring division step: shift in the next dividend bit, try the
  // subtraction and keep it when it does not go negative.
  assign rem_sh  = {rem_r[KW-1:0], dq_r[PW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  // Truncating division of a signed dividend: divide magnitudes, then give
  // the quotient the dividend's sign.
  assign quot_s   = {1'b0, dq_r[VW-1:0]};
  assign result_s = {v0_r[VW-1], v0_r} + (dv_neg_r ? -quot_s : quot_s);

  assign req_fire = in_req.valid && in_req.ready;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    k0_nxt      = k0_r;
    v0_nxt      = v0_r;
    den_nxt     = den_r;
    dk_nxt      = dk_r;
    dv_mag_nxt  = dv_mag_r;
    dv_neg_nxt  = dv_neg_r;
    dq_nxt      = dq_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    status_nxt  = status_r;
    value_nxt   = value_r;
    mem_we      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (req_fire) begin
          case (in_req.cmd)
            pli_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            pli_pkg::CMD_APPEND: begin
              if (count_r < CW'(pli_pkg::TABLE_DEPTH)) begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            pli_pkg::CMD_QUERY: begin
              key_nxt = in_req.arg_key;
              idx_nxt = '0;
              if (count_r == '0) begin
                status_nxt = pli_pkg::STAT_BELOW;
                value_nxt  = '0;
                state_nxt  = ST_OUT;
              end else begin
                state_nxt = ST_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_LOAD: begin
        // First breakpoint is on the read port now.
        k0_nxt = rd_key;
        v0_nxt = rd_val;
        if (count_r == CW'(1)) begin
          value_nxt = '0;
          if (key_r == rd_key) begin
            status_nxt = pli_pkg::STAT_OK;
            value_nxt  = rd_val;
          end else if (key_r < rd_key) begin
            status_nxt = pli_pkg::STAT_BELOW;
          end else begin
            status_nxt = pli_pkg::STAT_ABOVE;
          end
          state_nxt = ST_OUT;
        end else begin
          idx_nxt   = IW'(1);
          state_nxt = ST_WALK;
        end
      end

      ST_WALK: begin
        // Span from (k0_r, v0_r) to the breakpoint on the read port.
        value_nxt = '0;
        if (key_r < k0_r) begin
          status_nxt = pli_pkg::STAT_BELOW;
          state_nxt  = ST_OUT;
        end else if (key_r <= rd_key) begin
          status_nxt = pli_pkg::STAT_OK;
          if (key_r == k0_r) begin
            value_nxt = v0_r;
            state_nxt = ST_OUT;
          end else if (key_r == rd_key) begin
            value_nxt = rd_val;
            state_nxt = ST_OUT;
          end else begin
            den_nxt    = span_diff[KW-1:0];
            dk_nxt     = key_diff[KW-1:0];
            dv_neg_nxt = val_diff[VW];
            dv_mag_nxt = val_diff[VW] ? VW'(-val_diff) : val_diff[VW-1:0];
            state_nxt  = ST_MUL;
          end
        end else begin
          k0_nxt = rd_key;
          v0_nxt = rd_val;
          if ((CW'(idx_r) + CW'(1)) == count_r) begin
            status_nxt = pli_pkg::STAT_ABOVE;
            state_nxt  = ST_OUT;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end

      ST_MUL: begin
        dq_nxt      = PW'(dv_mag_r) * PW'(dk_r);
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end

      ST_DIV: begin
        if (!rem_sub[KW]) begin
          rem_nxt = rem_sub;
          dq_nxt  = {dq_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          dq_nxt  = {dq_r[PW-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + DW'(1);
        if (div_cnt_r == DW'(pli_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_ADJ;
        end
      end

      ST_ADJ: begin
        value_nxt  = result_s[VW-1:0];
        status_nxt = pli_pkg::STAT_OK;
        state_nxt  = ST_OUT;
      end

      ST_OUT: begin
        if (out_rsp.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    k0_r      <= k0_nxt;
    v0_r      <= v0_nxt;
    den_r     <= den_nxt;
    dk_r      <= dk_nxt;
    dv_mag_r  <= dv_mag_nxt;
    dv_neg_r  <= dv_neg_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    status_r  <= status_nxt;
    value_r   <= value_nxt;
  end

  // The read port follows the next walk index, so rdata_r always holds the
  // entry that idx_r points at.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bp_mem[count_r[IW-1:0]] <= {in_req.arg_key, in_req.arg_value};
    end
    rdata_r <= bp_mem[idx_nxt];
  end

  assign in_req.ready      = (state_r == ST_IDLE);
  assign out_rsp.valid     = (state_r == ST_OUT);
  assign out_rsp.status    = status_r;
  assign out_rsp.out_value = value_r;

endmodule

[rtl/core/pli_checker.sv]
// Port-level checks for the interpolator, bound to the interpolator unit.
// Depends on pli_pkg for the command and status codes.
module pli_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [1:0]                        in_cmd,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_status,
  input logic signed [pli_pkg::VAL_W-1:0]  out_value
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value))
    else $error("stalled result changed");

  // The block never takes a request while a result is waiting.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  // An accepted query keeps the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == pli_pkg::CMD_QUERY |=> !in_ready)
    else $error("query did not occupy the block");

  // Only an in-range result carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pli_pkg::STAT_OK |-> out_value == '0)
    else $error("value not zero for an out-of-range result");

  // Once the result is taken, the block is ready again.
  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("block not ready after result handed over");

endmodule

bind piecewise_linear_interpolator_unit pli_checker u_pli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .in_cmd     (in_req.cmd),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_status (out_rsp.status),
  .out_value  (out_rsp.out_value)
);
